/* design/shcs_pkg.sv */
// Shared constants and controller-datapath interface types for the spatial hash counting sort.
`default_nettype none
package shcs_pkg;

	localparam logic [31:0] HASH_MUL_X     = 32'd92837111;
	localparam logic [31:0] HASH_MUL_Y     = 32'd689287499;
	localparam logic [31:0] INV_CELL_RESET = 32'd65536;
	localparam int          MOD_STEPS      = 2;

	typedef struct packed {
		logic take_in;
		logic mul1;
		logic mul2;
		logic mag_ld;
		logic mod_step;
		logic hash_wr;
		logic cnt_sel_b;
		logic hash_sel_out;
		logic cnt_wr_zero;
		logic cnt_wr_inc;
		logic pref_wr;
		logic sorted_wr;
		logic i_inc;
		logic loaded_clr;
	} shcs_cmd_t;

	typedef struct packed {
		logic last;
		logic full;
		logic mod_done;
		logic b_last;
		logic i_last;
	} shcs_sts_t;

endpackage
`default_nettype wire

/* design/shcs_ctrl.sv */
// Controller state machine that sequences loading, counting, prefix, scatter, output and clearing.
`default_nettype none
module shcs_ctrl import shcs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	input  wire logic      s_tlast,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire shcs_sts_t sts,
	output shcs_cmd_t      cmd
);

	typedef enum logic [18:0] {
		ST_CLR  = 19'h00001,
		ST_IDLE = 19'h00002,
		ST_MUL1 = 19'h00004,
		ST_MUL2 = 19'h00008,
		ST_ABS  = 19'h00010,
		ST_MOD  = 19'h00020,
		ST_LOAD = 19'h00040,
		ST_CRH  = 19'h00080,
		ST_CRC  = 19'h00100,
		ST_CWR  = 19'h00200,
		ST_PRD  = 19'h00400,
		ST_PWR  = 19'h00800,
		ST_SRH  = 19'h01000,
		ST_SRC  = 19'h02000,
		ST_SWR  = 19'h04000,
		ST_ORS  = 19'h08000,
		ST_ORH  = 19'h10000,
		ST_ORB  = 19'h20000,
		ST_OUT  = 19'h40000
	} state_t;

	state_t state_q;
	state_t nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt      = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_CLR: begin
				cmd.cnt_sel_b   = 1'b1;
				cmd.cnt_wr_zero = 1'b1;
				if (sts.b_last) nxt = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take_in = 1'b1;
					if (!sts.full) nxt = ST_MUL1;
					else if (s_tlast) nxt = ST_CRH;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				nxt = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				nxt = ST_ABS;
			end
			ST_ABS: begin
				cmd.mag_ld = 1'b1;
				nxt = ST_MOD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) nxt = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.hash_wr = 1'b1;
				nxt = sts.last ? ST_CRH : ST_IDLE;
			end
			ST_CRH: nxt = ST_CRC;
			ST_CRC: nxt = ST_CWR;
			ST_CWR: begin
				cmd.cnt_wr_inc = 1'b1;
				cmd.i_inc      = 1'b1;
				nxt = sts.i_last ? ST_PRD : ST_CRH;
			end
			ST_PRD: begin
				cmd.cnt_sel_b = 1'b1;
				nxt = ST_PWR;
			end
			ST_PWR: begin
				cmd.cnt_sel_b = 1'b1;
				cmd.pref_wr   = 1'b1;
				nxt = sts.b_last ? ST_SRH : ST_PRD;
			end
			ST_SRH: nxt = ST_SRC;
			ST_SRC: nxt = ST_SWR;
			ST_SWR: begin
				cmd.cnt_wr_inc = 1'b1;
				cmd.sorted_wr  = 1'b1;
				cmd.i_inc      = 1'b1;
				nxt = sts.i_last ? ST_ORS : ST_SRH;
			end
			ST_ORS: nxt = ST_ORH;
			ST_ORH: begin
				cmd.hash_sel_out = 1'b1;
				nxt = ST_ORB;
			end
			ST_ORB: begin
				cmd.hash_sel_out = 1'b1;
				nxt = ST_OUT;
			end
			ST_OUT: begin
				cmd.hash_sel_out = 1'b1;
				m_tvalid = 1'b1;
				if (m_tready) begin
					cmd.i_inc = 1'b1;
					if (sts.i_last) begin
						cmd.loaded_clr = 1'b1;
						nxt = ST_CLR;
					end else begin
						nxt = ST_ORS;
					end
				end
			end
			default: nxt = ST_CLR;
		endcase
	end

endmodule
`default_nettype wire

/* design/shcs_dp.sv */
// Datapath: cell hashing, remainder unit, bin and slot memories, counters and result fields.
`default_nettype none
module shcs_dp import shcs_pkg::*; #(
	parameter int MAX_PARTICLES = 64,
	parameter int BIN_COUNT     = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire shcs_cmd_t   cmd,
	output shcs_sts_t        sts,
	input  wire logic [63:0] s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        cfg_valid,
	input  wire logic [31:0] cfg_data,
	output logic      [31:0] m_tdata,
	output logic             m_tlast
);

	localparam int IW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int BW = $clog2(BIN_COUNT);
	localparam int RW = BW + 2;
	localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / BIN_COUNT);
	localparam logic [RW-1:0] BIN_D = RW'(BIN_COUNT);
	localparam logic [BW-1:0] B_END = BW'(BIN_COUNT - 1);
	localparam logic [CW-1:0] MAX_N = CW'(MAX_PARTICLES);

	logic [31:0] inv_q;
	logic [31:0] px_q, py_q;
	logic        last_q;
	logic [31:0] cx_q, cy_q, hx_q, hy_q, mag_q, qest_q;
	logic [BW-1:0] rem_q;
	logic [4:0]    modc_q;
	logic [CW-1:0] loaded_q, acc_q;
	logic [IW-1:0] i_q;
	logic [BW-1:0] b_q;

	logic [BW-1:0] hash_mem   [MAX_PARTICLES];
	logic [IW-1:0] sorted_mem [MAX_PARTICLES];
	logic [CW-1:0] cnt_mem    [BIN_COUNT];
	logic [CW-1:0] start_mem  [BIN_COUNT];

	logic [BW-1:0] hrd_q;
	logic [CW-1:0] crd_q, strd_q;
	logic [IW-1:0] srd_q;

	logic signed [32:0] ax, ay, bm;
	logic signed [65:0] prod_x, prod_y;
	logic [31:0]   hmix, habs;
	logic [63:0]   qprod;
	logic [RW-1:0] r_est, r_fix;
	logic [IW-1:0] hash_addr;
	logic [BW-1:0] cnt_addr;
	logic [CW-1:0] cnt_wdata, last_slot;
	logic          full, i_last, b_last;

	assign ax     = {px_q[31], px_q};
	assign ay     = {py_q[31], py_q};
	assign bm     = {1'b0, inv_q};
	assign prod_x = ax * bm;
	assign prod_y = ay * bm;
	assign hmix   = hx_q ^ hy_q;
	assign habs   = hmix[31] ? (~hmix + 32'd1) : hmix;
	assign qprod  = 64'(mag_q) * 64'(RECIP);
	assign r_est  = mag_q[RW-1:0] - qest_q[RW-1:0] * BIN_D;
	assign r_fix  = (r_est >= BIN_D) ? (r_est - BIN_D) : r_est;

	assign full   = (loaded_q == MAX_N);
	assign i_last = ((CW'(i_q) + CW'(1)) == loaded_q);
	assign b_last = (b_q == B_END);

	assign sts.last     = last_q;
	assign sts.full     = full;
	assign sts.mod_done = (modc_q == 5'(MOD_STEPS - 1));
	assign sts.b_last   = b_last;
	assign sts.i_last   = i_last;

	assign hash_addr = cmd.hash_sel_out ? srd_q : i_q;
	assign cnt_addr  = cmd.cnt_sel_b ? b_q : hrd_q;

	always_comb begin
		if (cmd.pref_wr) cnt_wdata = acc_q;
		else if (cmd.cnt_wr_inc) cnt_wdata = crd_q + CW'(1);
		else cnt_wdata = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q    <= INV_CELL_RESET;
			loaded_q <= '0;
			i_q      <= '0;
			b_q      <= '0;
			acc_q    <= '0;
			modc_q   <= '0;
		end else begin
			if (cfg_valid) inv_q <= cfg_data;
			if (cmd.loaded_clr) loaded_q <= '0;
			else if (cmd.hash_wr && !full) loaded_q <= loaded_q + CW'(1);
			if (cmd.i_inc) i_q <= i_last ? '0 : i_q + IW'(1);
			if (cmd.cnt_wr_zero || cmd.pref_wr) b_q <= b_last ? '0 : b_q + BW'(1);
			if (cmd.pref_wr) acc_q <= b_last ? '0 : acc_q + crd_q;
			if (cmd.mag_ld) modc_q <= '0;
			else if (cmd.mod_step) modc_q <= modc_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			px_q   <= s_tdata[31:0];
			py_q   <= s_tdata[63:32];
			last_q <= s_tlast;
		end
		if (cmd.mul1) begin
			cx_q <= prod_x[63:32];
			cy_q <= prod_y[63:32];
		end
		if (cmd.mul2) begin
			hx_q <= cx_q * HASH_MUL_X;
			hy_q <= cy_q * HASH_MUL_Y;
		end
		if (cmd.mag_ld) mag_q <= habs;
		if (cmd.mod_step) begin
			if (modc_q == 5'd0) qest_q <= qprod[63:32];
			else rem_q <= r_fix[BW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hash_wr && !full) hash_mem[loaded_q[IW-1:0]] <= rem_q;
		if (cmd.sorted_wr) sorted_mem[crd_q[IW-1:0]] <= i_q;
		if (cmd.cnt_wr_zero || cmd.cnt_wr_inc || cmd.pref_wr) cnt_mem[cnt_addr] <= cnt_wdata;
		if (cmd.pref_wr) start_mem[b_q] <= acc_q;
		hrd_q  <= hash_mem[hash_addr];
		srd_q  <= sorted_mem[i_q];
		crd_q  <= cnt_mem[cnt_addr];
		strd_q <= start_mem[cnt_addr];
	end

	assign last_slot = crd_q - CW'(1);
	assign m_tdata   = {6'(last_slot), 6'(strd_q), 8'(hrd_q), 6'(srd_q), 6'(i_q)};
	assign m_tlast   = i_last;

endmodule
`default_nettype wire

/* design/spatial_hash_counting_sort.sv */
// Top level of the spatial hash counting sort: controller and datapath.
// The block takes particle positions on the s_ stream, one transaction per particle,
// and on the particle marked by s_tlast sorts the batch by hash bin. It then sends one
// m_ transaction per sorted slot, the batch's final slot marked by m_tlast.
// The reciprocal cell size is written through cfg_valid/cfg_data; the user must write
// it only while the block is idle, as the block itself does not enforce this. Loading
// takes each particle through the two multiplier stages and the two-step remainder
// unit before the next is taken; particles beyond MAX_PARTICLES are dropped. After the
// final particle the sort counts bins, runs the prefix pass, scatters, delivers the
// results through the single-port slot memories, then clears the bin counters.
// After reset a clearing pass over the bin counters runs before s_tready rises.
// While m_tready is low the current result holds and the block waits; no new
// particle is taken until every result of the batch has been delivered.
`default_nettype none
module spatial_hash_counting_sort import shcs_pkg::*; #(
	parameter int MAX_PARTICLES = 64,
	parameter int BIN_COUNT     = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // pos_x, pos_y
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // slot, particle_id, bin_key, bin_first, bin_last
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	shcs_cmd_t cmd;
	shcs_sts_t sts;

	assign cfg_ready = 1'b1;

	shcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	shcs_dp #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.BIN_COUNT     (BIN_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

/* design/shcs_checker.sv */
// Port checker for the spatial hash counting sort and its bind to the top level.
`default_nettype none
module shcs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tlast
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while a result is pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_last_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input open after final particle");

	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("results issued back to back");

	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !s_tready)
		else $error("input open before counters cleared");

endmodule

bind spatial_hash_counting_sort shcs_checker u_shcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
